// ===== hw/rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types, codes and helpers for the PTT transmit sequencer.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int DELAY_SCALE = 10;
  localparam int CNT_W       = 12;
  localparam int NUM_LINES   = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // commands
  localparam logic [2:0] CMD_FOOT_PRESS   = 3'd0;
  localparam logic [2:0] CMD_FOOT_RELEASE = 3'd1;
  localparam logic [2:0] CMD_RTS_ON       = 3'd2;
  localparam logic [2:0] CMD_RTS_OFF      = 3'd3;
  localparam logic [2:0] CMD_LOCK_ALL     = 3'd4;
  localparam logic [2:0] CMD_TICK         = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_INPUT_ENABLES = 3'd0;
  localparam logic [2:0] REG_FOOT_MASK     = 3'd1;
  localparam logic [2:0] REG_COMP_MASK     = 3'd2;
  localparam logic [2:0] REG_FOOT_PRE      = 3'd3;
  localparam logic [2:0] REG_FOOT_POST     = 3'd4;
  localparam logic [2:0] REG_COMP_PRE      = 3'd5;
  localparam logic [2:0] REG_COMP_POST     = 3'd6;

  // line slots
  localparam int LN_TX    = 0;
  localparam int LN_AMP   = 1;
  localparam int LN_RADIO = 2;
  localparam int LN_INH   = 3;

  // pending actions
  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ON   = 2'd1;
  localparam logic [1:0] ACT_OFF  = 2'd2;

  // operations handed from front to back
  localparam logic [1:0] OP_NONE  = 2'd0;
  localparam logic [1:0] OP_KEYUP = 2'd1;
  localparam logic [1:0] OP_KEYDN = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic       send_allowed;
  } in_req_t;

  typedef struct packed {
    logic       tx_active;
    logic       amp_key;
    logic       radio_key;
    logic       inhibit_level;
    logic [1:0] sources_active;
  } out_res_t;

  typedef struct packed {
    logic [2:0]  input_enables;
    logic [2:0]  foot_mask;
    logic [2:0]  comp_mask;
    logic [23:0] foot_pre;
    logic [31:0] foot_post;
    logic [23:0] comp_pre;
    logic [31:0] comp_post;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                      op;
    logic [NUM_LINES-1:0]            en;
    logic [NUM_LINES-1:0][CNT_W-1:0] ticks;
    logic [1:0]                      sources;
  } line_op_t;

  // delay byte times scale, saturated to the countdown range
  function automatic logic [CNT_W-1:0] delay_ticks(input logic [7:0] b);
    logic [15:0] p;
    p = 16'(b) * 16'(DELAY_SCALE);
    return (p > 16'(CNT_MAX)) ? CNT_MAX : p[CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/ptt_front.sv =====
// ----------------------------------------------------------------------------
// ptt_front
// Classifies each request against the enables and source state, tracks the
// active sources and issues one line operation per request.
// ----------------------------------------------------------------------------
module ptt_front import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     req_take,
  input  in_req_t  req,
  output line_op_t op_out
);

  logic [1:0] src_r, src_nxt;
  logic       foot_en, comp_en;

  assign foot_en = cfg.input_enables[0];
  assign comp_en = cfg.input_enables[1];

  always_comb begin
    op_out         = '0;
    op_out.op      = OP_NONE;
    src_nxt        = src_r;
    case (req.cmd)
      CMD_FOOT_PRESS: begin
        if (foot_en && !src_r[1] && req.send_allowed) begin
          op_out.op               = OP_KEYUP;
          op_out.en               = {cfg.foot_mask[2], cfg.foot_mask[1],
                                     cfg.foot_mask[0], 1'b1};
          op_out.ticks[LN_AMP]    = delay_ticks(cfg.foot_pre[7:0]);
          op_out.ticks[LN_RADIO]  = delay_ticks(cfg.foot_pre[15:8]);
          op_out.ticks[LN_INH]    = delay_ticks(cfg.foot_pre[23:16]);
          src_nxt[0]              = 1'b1;
        end
      end
      CMD_RTS_ON: begin
        if (comp_en && !src_r[0] && req.send_allowed) begin
          op_out.op               = OP_KEYUP;
          op_out.en               = {cfg.comp_mask[2], cfg.comp_mask[1],
                                     cfg.comp_mask[0], 1'b1};
          op_out.ticks[LN_AMP]    = delay_ticks(cfg.comp_pre[7:0]);
          op_out.ticks[LN_RADIO]  = delay_ticks(cfg.comp_pre[15:8]);
          op_out.ticks[LN_INH]    = delay_ticks(cfg.comp_pre[23:16]);
          src_nxt[1]              = 1'b1;
        end
      end
      CMD_FOOT_RELEASE: begin
        if (foot_en) begin
          // blocked while the other source keys
          if (!comp_en || !src_r[1]) begin
            op_out.op              = OP_KEYDN;
            op_out.en              = '1;
            op_out.ticks[LN_RADIO] = delay_ticks(cfg.foot_post[7:0]);
            op_out.ticks[LN_AMP]   = delay_ticks(cfg.foot_post[15:8]);
            op_out.ticks[LN_TX]    = delay_ticks(cfg.foot_post[23:16]);
            op_out.ticks[LN_INH]   = delay_ticks(cfg.foot_post[31:24]);
          end
          src_nxt[0] = 1'b0;
        end
      end
      CMD_RTS_OFF: begin
        if (comp_en) begin
          if (!foot_en || !src_r[0]) begin
            op_out.op              = OP_KEYDN;
            op_out.en              = '1;
            op_out.ticks[LN_RADIO] = delay_ticks(cfg.comp_post[7:0]);
            op_out.ticks[LN_AMP]   = delay_ticks(cfg.comp_post[15:8]);
            op_out.ticks[LN_TX]    = delay_ticks(cfg.comp_post[23:16]);
            op_out.ticks[LN_INH]   = delay_ticks(cfg.comp_post[31:24]);
          end
          src_nxt[1] = 1'b0;
        end
      end
      CMD_LOCK_ALL: begin
        op_out.op              = OP_KEYDN;
        op_out.en              = '1;
        op_out.ticks[LN_RADIO] = delay_ticks(cfg.foot_post[7:0]);
        op_out.ticks[LN_AMP]   = delay_ticks(cfg.foot_post[15:8]);
        op_out.ticks[LN_TX]    = delay_ticks(cfg.foot_post[23:16]);
        op_out.ticks[LN_INH]   = delay_ticks(cfg.foot_post[31:24]);
        src_nxt                = 2'b00;
      end
      CMD_TICK: begin
        op_out.op = OP_TICK;
      end
      default: begin
        op_out.op = OP_NONE;
      end
    endcase
    op_out.sources = src_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= 2'b00;
    end else if (req_take) begin
      src_r <= src_nxt;
    end
  end

endmodule

// ===== hw/rtl/ptt_queue.sv =====
// ----------------------------------------------------------------------------
// ptt_queue
// Two-entry queue of line operations between front and back.
// ----------------------------------------------------------------------------
module ptt_queue import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  line_op_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     not_empty,
  output line_op_t head
);

  line_op_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/ptt_back.sv =====
// ----------------------------------------------------------------------------
// ptt_back
// Four line slots with one pending action each; applies line operations and
// holds the result register.
// ----------------------------------------------------------------------------
module ptt_back import ptt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     polarity,
  input  logic     op_valid,
  input  line_op_t op_in,
  output logic     op_take,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  logic [NUM_LINES-1:0]            asserted_r, asserted_nxt;
  logic [NUM_LINES-1:0][1:0]       act_r, act_nxt;
  logic [NUM_LINES-1:0][CNT_W-1:0] cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  out_res_t                        out_data_r;

  assign op_take   = op_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    asserted_nxt = asserted_r;
    act_nxt      = act_r;
    cnt_nxt      = cnt_r;
    for (int i = 0; i < NUM_LINES; i++) begin
      case (op_in.op)
        OP_KEYUP: begin
          if (op_in.en[i]) begin
            if (op_in.ticks[i] == '0) begin
              asserted_nxt[i] = 1'b1;
              act_nxt[i]      = ACT_NONE;
              cnt_nxt[i]      = '0;
            end else begin
              act_nxt[i] = ACT_ON;
              cnt_nxt[i] = op_in.ticks[i];
            end
          end
        end
        OP_KEYDN: begin
          if (op_in.en[i]) begin
            // a release cancels a pending key-up
            if (act_r[i] == ACT_ON) begin
              act_nxt[i] = ACT_NONE;
              cnt_nxt[i] = '0;
            end else if (op_in.ticks[i] == '0) begin
              asserted_nxt[i] = 1'b0;
              act_nxt[i]      = ACT_NONE;
              cnt_nxt[i]      = '0;
            end else begin
              act_nxt[i] = ACT_OFF;
              cnt_nxt[i] = op_in.ticks[i];
            end
          end
        end
        OP_TICK: begin
          if (act_r[i] != ACT_ON && act_r[i] != ACT_OFF) begin
            act_nxt[i] = ACT_NONE;
          end else begin
            if (cnt_r[i] != '0) begin
              cnt_nxt[i] = cnt_r[i] - 1'b1;
            end
            if (cnt_r[i] <= CNT_W'(1)) begin
              asserted_nxt[i] = (act_r[i] == ACT_ON);
              act_nxt[i]      = ACT_NONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (op_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asserted_r  <= '0;
      act_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (op_take) begin
        asserted_r <= asserted_nxt;
        act_r      <= act_nxt;
        cnt_r      <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_take) begin
      out_data_r.tx_active      <= asserted_nxt[LN_TX];
      out_data_r.amp_key        <= asserted_nxt[LN_AMP];
      out_data_r.radio_key      <= asserted_nxt[LN_RADIO];
      out_data_r.inhibit_level  <= asserted_nxt[LN_INH] ? polarity : ~polarity;
      out_data_r.sources_active <= op_in.sources;
    end
  end

endmodule

// ===== hw/rtl/ptt_transmit_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// ptt_transmit_sequencer_top
// PTT transmit sequencer: keys tx-active, amplifier, radio and inhibit lines
// with per-line pre- and post-delays counted in 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per event (foot press/release, rts on/off, lock all,
//           tick) with the send-allowed flag; taken when in_valid && !in_stall.
//   out_* : one result per request, the line levels and active sources after
//           that request; taken when out_valid && !out_stall.
//   cfg_* : register writes by index, applied on the edge cfg_we is high;
//           write only while no request is in flight.
// Requests are queued and results registered; one request per cycle is
// sustained while out_stall is low, set by the back-end line-slot update.
// A two-entry queue separates classification from the line slots, so the
// input keeps taking requests while a result waits; with out_stall held the
// queue fills and in_stall rises after two further requests.
// Reset clears the configuration, queue pointers, sources and pending
// actions, and releases every line.
// ----------------------------------------------------------------------------
module ptt_transmit_sequencer_top import ptt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cfg_t     cfg_r;
  line_op_t front_op;
  line_op_t q_head;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     in_take;

  assign in_stall = q_full;
  assign in_take  = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_ENABLES: cfg_r.input_enables <= cfg_wdata[2:0];
        REG_FOOT_MASK:     cfg_r.foot_mask     <= cfg_wdata[2:0];
        REG_COMP_MASK:     cfg_r.comp_mask     <= cfg_wdata[2:0];
        REG_FOOT_PRE:      cfg_r.foot_pre      <= cfg_wdata[23:0];
        REG_FOOT_POST:     cfg_r.foot_post     <= cfg_wdata;
        REG_COMP_PRE:      cfg_r.comp_pre      <= cfg_wdata[23:0];
        REG_COMP_POST:     cfg_r.comp_post     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  ptt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .req_take (in_take),
    .req      (in_data),
    .op_out   (front_op)
  );

  ptt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_data (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  ptt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .polarity  (cfg_r.input_enables[2]),
    .op_valid  (q_not_empty),
    .op_in     (q_head),
    .op_take   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/ptt_checker.sv =====
// ----------------------------------------------------------------------------
// ptt_checker
// Port-level checks for the PTT transmit sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input out_res_t    out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // reset leaves the pipeline empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // the two sources never key at once
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.sources_active != 2'b11)
    else $error("both sources reported keying");

endmodule

bind ptt_transmit_sequencer_top ptt_checker u_ptt_checker (.*);
